>>> src/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants for the PS/2 mouse cursor decoder.
// Holds the mode and packet phase codes, fixed field widths and reset values.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // Screen size registers are 13 bits wide so that 4096 fits.
  localparam int unsigned SIZE_BITS = 13;

  // Controller status bit that marks a byte from the auxiliary port, the
  // sync bit of the first packet byte and the button bits of that byte.
  localparam logic [7:0] AUX_BIT  = 8'h20;
  localparam logic [7:0] SYNC_BIT = 8'h08;
  localparam logic [2:0] BTN_MASK = 3'h7;

  localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd1280;
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd720;
  localparam int unsigned          RESET_X      = 640;
  localparam int unsigned          RESET_Y      = 360;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_CENTER = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

endpackage

>>> src/ps2_mouse_packet_cursor_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_top: 3-byte PS/2 mouse packet decoder with cursor.
// Takes one word per cycle while the skid entry is free; each result is registered.
// The two-entry output buffer (result register and skid) sets the rate.
// Async active-low reset: cursor 640/360, phase, buttons and flags cleared.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_top
  import pmc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [SIZE_BITS-1:0]  cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic                  aux_data_i,
  input  logic [7:0]            data_byte_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic [2:0]            buttons_o,
  output logic                  moved_o,
  output logic                  packet_done_o
);

  // Working width for the signed position arithmetic: wide enough for the
  // larger of a coordinate and a screen size, plus sign and carry.
  localparam int unsigned WB = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

  localparam logic [COORD_BITS-1:0] ResetPosX = COORD_BITS'(RESET_X);
  localparam logic [COORD_BITS-1:0] ResetPosY = COORD_BITS'(RESET_Y);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [2:0]            buttons;
    logic                  moved;
    logic                  done;
  } result_t;

  // Largest legal coordinate for a screen size. A size of zero behaves as
  // one, and the bound never exceeds what a coordinate register can hold.
  function automatic logic [WB-1:0] max_coord(input logic [SIZE_BITS-1:0] size);
    logic [SIZE_BITS-1:0] m;
    logic [WB-1:0]        mw;
    logic [WB-1:0]        lim;
    m   = (size == '0) ? '0 : size - SIZE_BITS'(1);
    mw  = WB'(m);
    lim = WB'({COORD_BITS{1'b1}});
    return (mw > lim) ? lim : mw;
  endfunction

  // Screen center, never past the largest coordinate.
  function automatic logic [COORD_BITS-1:0] centre(input logic [SIZE_BITS-1:0] size);
    logic [SIZE_BITS-1:0] eff;
    logic [WB-1:0]        c;
    logic [WB-1:0]        m;
    eff = (size == '0) ? SIZE_BITS'(1) : size;
    c   = WB'(eff >> 1);
    m   = max_coord(size);
    return COORD_BITS'((c > m) ? m : c);
  endfunction

  // Add a signed step and clamp the result to 0..max.
  function automatic logic [COORD_BITS-1:0] move_axis(input logic [COORD_BITS-1:0] pos,
                                                      input logic [8:0]            step,
                                                      input logic [SIZE_BITS-1:0]  size);
    logic signed [WB-1:0] p;
    logic signed [WB-1:0] m;
    p = $signed(WB'(pos)) + $signed({{(WB-9){step[8]}}, step});
    m = $signed(max_coord(size));
    if (p < 0) begin
      p = '0;
    end
    if (p > m) begin
      p = m;
    end
    return COORD_BITS'(p);
  endfunction

  // Configuration registers.
  logic [SIZE_BITS-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Decoder state.
  phase_e                phase_q, phase_d;
  logic [2:0]            held_btn_q, held_btn_d;
  logic [7:0]            held_dx_q, held_dx_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
  logic [2:0]            btn_q, btn_d;
  logic                  moved_q, moved_d;
  result_t               res;

  // The output side is a result register backed by one skid entry. The input
  // is stalled only when the skid entry is full, so stall is a plain register
  // and a word is still taken while the previous result waits downstream.
  logic    accept;
  logic    out_free;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state and the result for the word on the input ports.
  always_comb begin
    logic [8:0] dy;
    phase_d    = phase_q;
    held_btn_d = held_btn_q;
    held_dx_d  = held_dx_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    btn_d      = btn_q;
    moved_d    = moved_q;
    res.done   = 1'b0;
    // The Y axis of the mouse points up, the screen's points down.
    dy         = 9'd0 - {data_byte_i[7], data_byte_i};
    case (mode_e'(mode_i))
      MODE_BYTE: begin
        if (aux_data_i) begin
          case (phase_q)
            PH_SYNC: begin
              // A first byte without the sync bit is dropped to resync.
              if ((data_byte_i & SYNC_BIT) != '0) begin
                held_btn_d = data_byte_i[2:0] & BTN_MASK;
                phase_d    = PH_X;
              end
            end
            PH_X: begin
              held_dx_d = data_byte_i;
              phase_d   = PH_Y;
            end
            default: begin
              pos_x_d  = move_axis(pos_x_q, {held_dx_q[7], held_dx_q}, width_q);
              pos_y_d  = move_axis(pos_y_q, dy, height_q);
              btn_d    = held_btn_q;
              moved_d  = 1'b1;
              phase_d  = PH_SYNC;
              res.done = 1'b1;
            end
          endcase
        end
      end
      MODE_CLEAR: begin
        moved_d = 1'b0;
      end
      MODE_CENTER: begin
        // Recentering leaves a partly received packet where it is.
        pos_x_d = centre(width_q);
        pos_y_d = centre(height_q);
      end
      default: ;
    endcase
    res.x       = pos_x_d;
    res.y       = pos_y_d;
    res.buttons = btn_d;
    // A read-and-clear reports the flag as it was before clearing.
    res.moved   = res.done ? 1'b1 : moved_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC;
      held_btn_q <= '0;
      held_dx_q  <= '0;
      pos_x_q    <= ResetPosX;
      pos_y_q    <= ResetPosY;
      btn_q      <= '0;
      moved_q    <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      held_btn_q <= held_btn_d;
      held_dx_q  <= held_dx_d;
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      btn_q      <= btn_d;
      moved_q    <= moved_d;
    end
  end

  // Result register and skid control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= skid_valid_q || accept;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = out_q.x;
  assign cursor_y_o    = out_q.y;
  assign buttons_o     = out_q.buttons;
  assign moved_o       = out_q.moved;
  assign packet_done_o = out_q.done;

`ifndef SYNTHESIS
  // A full skid entry always sits behind a full result register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while result register empty");

  // Every accepted word leaves a result waiting on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word produced no result");

  // A completed packet always reports the moved flag set.
  a_done_sets_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_done_o) |-> moved_o)
    else $error("packet completed without moved flag");
`endif

endmodule

>>> tb/ps2_mouse_packet_cursor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_checker: scoreboard for the PS/2 cursor decoder.
// Watches the configuration port and both word channels, predicts the cursor
// word for every accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_checker
  import pmc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [SIZE_BITS-1:0]  cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            mode_i,
  input  logic                  aux_data_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [COORD_BITS-1:0] cursor_x_i,
  input  logic [COORD_BITS-1:0] cursor_y_i,
  input  logic [2:0]            buttons_i,
  input  logic                  moved_i,
  input  logic                  packet_done_i,
  output int                    mismatch_count_o,
  output int                    words_pending_o
);

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [2:0]            buttons;
    logic                  moved;
    logic                  done;
  } cursor_word_t;

  cursor_word_t          cursor_words_due[$];
  logic [SIZE_BITS-1:0]  screen_w;
  logic [SIZE_BITS-1:0]  screen_h;
  phase_e                pkt_phase;
  logic [2:0]            pkt_buttons;
  logic [7:0]            pkt_dx;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [2:0]            button_state;
  logic                  moved_state;
  int                    mismatches = 0;

  // Largest coordinate on an axis; a size of zero behaves as a size of one.
  function automatic int axis_limit(input logic [SIZE_BITS-1:0] size);
    int lim;
    lim = (size == '0) ? 0 : int'(size) - 1;
    return (lim > COORD_MAX) ? COORD_MAX : lim;
  endfunction

  function automatic int axis_center(input logic [SIZE_BITS-1:0] size);
    int half;
    int lim;
    half = (size == '0) ? 0 : int'(size) / 2;
    lim  = axis_limit(size);
    return (half > lim) ? lim : half;
  endfunction

  function automatic logic [COORD_BITS-1:0] step_axis(input logic [COORD_BITS-1:0] pos,
                                                       input int step,
                                                       input logic [SIZE_BITS-1:0] size);
    int p;
    int lim;
    lim = axis_limit(size);
    p   = int'(pos);
    p   = p + step;
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    return p[COORD_BITS-1:0];
  endfunction

  task automatic predict_cursor_word(input mode_e m, input logic aux, input logic [7:0] b);
    cursor_word_t w;
    int           dx;
    int           dy;
    w.done = 1'b0;
    case (m)
      MODE_BYTE: begin
        // Bytes from the keyboard port leave everything as it is.
        if (aux) begin
          case (pkt_phase)
            PH_SYNC: begin
              if ((b & SYNC_BIT) != 8'h00) begin
                pkt_buttons = b[2:0] & BTN_MASK;
                pkt_phase   = PH_X;
              end
            end
            PH_X: begin
              pkt_dx    = b;
              pkt_phase = PH_Y;
            end
            default: begin
              dx           = int'($signed(pkt_dx));
              dy           = -int'($signed(b));
              pos_x        = step_axis(pos_x, dx, screen_w);
              pos_y        = step_axis(pos_y, dy, screen_h);
              button_state = pkt_buttons;
              moved_state  = 1'b1;
              pkt_phase    = PH_SYNC;
              w.done       = 1'b1;
            end
          endcase
        end
        w.moved = moved_state;
      end
      MODE_CLEAR: begin
        w.moved     = moved_state;
        moved_state = 1'b0;
      end
      MODE_CENTER: begin
        pos_x   = COORD_BITS'(axis_center(screen_w));
        pos_y   = COORD_BITS'(axis_center(screen_h));
        w.moved = moved_state;
      end
      default: begin
        w.moved = moved_state;
      end
    endcase
    w.x       = pos_x;
    w.y       = pos_y;
    w.buttons = button_state;
    cursor_words_due.push_back(w);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cursor_word_t want;
    if (!rst_ni) begin
      screen_w     = RESET_WIDTH;
      screen_h     = RESET_HEIGHT;
      pkt_phase    = PH_SYNC;
      pkt_buttons  = '0;
      pkt_dx       = '0;
      pos_x        = COORD_BITS'(RESET_X);
      pos_y        = COORD_BITS'(RESET_Y);
      button_state = '0;
      moved_state  = 1'b0;
      cursor_words_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (reg_idx_e'(cfg_idx_i) == REG_WIDTH) screen_w = cfg_data_i;
        else screen_h = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_cursor_word(mode_e'(mode_i), aux_data_i, data_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (cursor_words_due.size() == 0) begin
          mismatches++;
          $display("%0t: cursor word with nothing expected, expected none, got x=%0d y=%0d",
                   $time, cursor_x_i, cursor_y_i);
        end else begin
          want = cursor_words_due.pop_front();
          compare_field("cursor_x", 32'(want.x), 32'(cursor_x_i));
          compare_field("cursor_y", 32'(want.y), 32'(cursor_y_i));
          compare_field("buttons", 32'(want.buttons), 32'(buttons_i));
          compare_field("moved", 32'(want.moved), 32'(moved_i));
          compare_field("packet_done", 32'(want.done), 32'(packet_done_i));
        end
      end
    end
    mismatch_count_o <= mismatches;
    words_pending_o  <= cursor_words_due.size();
  end

endmodule

>>> tb/ps2_mouse_packet_cursor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_top_tb: testbench for the PS/2 cursor decoder.
// Drives directed and random mouse byte streams under several screen sizes,
// with random gaps and stalls on both channels; the checker predicts results.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_top_tb;
  import pmc_pkg::*;

  localparam int COORD_BITS  = 12;
  // The limit leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 600000;
  // Length of the deliberate receiver hold-off that backs up the pipeline.
  localparam int HOLD_CYCLES = 200;
  // Extra cycles after the last result.
  localparam int DRAIN_SLACK = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_idx;
  logic [SIZE_BITS-1:0]  cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            mode;
  logic                  aux_data;
  logic [7:0]            data_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [2:0]            buttons;
  logic                  moved;
  logic                  packet_done;

  int mismatches;
  int pending;

  // Sender-side bookkeeping. The offering bit mirrors in_valid so that no
  // task ever schedules a second assignment to it within one time step.
  bit offering = 1'b0;
  bit gaps_on  = 1'b1;
  // Preferred direction of the cursor drift, so that the edges get reached.
  bit drift    = 1'b0;
  // Each increment asks the receiver for one long hold-off.
  int hold_seq = 0;

  always #5 clk = ~clk;

  ps2_mouse_packet_cursor_top #(
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .aux_data_i    (aux_data),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .cursor_x_o    (cursor_x),
    .cursor_y_o    (cursor_y),
    .buttons_o     (buttons),
    .moved_o       (moved),
    .packet_done_o (packet_done)
  );

  ps2_mouse_packet_cursor_checker #(
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .mode_i           (mode),
    .aux_data_i       (aux_data),
    .data_byte_i      (data_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .cursor_x_i       (cursor_x),
    .cursor_y_i       (cursor_y),
    .buttons_i        (buttons),
    .moved_i          (moved),
    .packet_done_i    (packet_done),
    .mismatch_count_o (mismatches),
    .words_pending_o  (pending)
  );

  // Receiver. Every cycle it either continues the current stretch of stall
  // or ready, or starts a new one. Most stretches are short, some ready
  // stretches are long so that bursts flow freely, and a few stalls are long.
  // A request from the stimulus starts the long hold-off immediately.
  initial begin
    int hold_seen;
    int left;
    int r;
    bit stall_now;
    hold_seen = 0;
    left      = 0;
    stall_now = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        stall_now = 1'b1;
        left      = HOLD_CYCLES;
      end else if (left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          stall_now = 1'b0;
          left      = $urandom_range(1, 6);
        end else if (r < 85) begin
          stall_now = 1'b1;
          left      = $urandom_range(1, 3);
        end else if (r < 95) begin
          stall_now = 1'b0;
          left      = $urandom_range(20, 80);
        end else begin
          stall_now = 1'b1;
          left      = $urandom_range(10, 40);
        end
      end
      left--;
      out_stall <= stall_now;
    end
  end

  // Gap after an accepted word: usually none, sometimes a few cycles and
  // now and then a long pause.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Offers one input word and holds it steady until the block takes it.
  task automatic send_item(input mode_e m, input logic aux, input logic [7:0] b);
    int gap;
    in_valid  <= 1'b1;
    offering   = 1'b1;
    mode      <= m;
    aux_data  <= aux;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    gap = gaps_on ? sender_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until the checker has seen every expected word.
  // The first edge lets the checker count a word accepted at this very edge.
  task automatic drain_results();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Writes both screen size registers while the block is idle.
  task automatic set_screen(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Motion byte: a good share pushes hard in the drift direction so that the
  // cursor runs into the screen edges; the rest is fully random.
  function automatic logic [7:0] pick_step();
    if ($urandom_range(0, 99) < 45) return drift ? 8'h7F : 8'h80;
    return 8'($urandom_range(0, 255));
  endfunction

  // Everything that is not a well-formed packet byte: keyboard bytes, stray
  // mouse bytes that may or may not carry the sync bit, and the other modes.
  task automatic send_noise();
    int         r;
    logic [7:0] b;
    logic       aux;
    r   = $urandom_range(0, 99);
    b   = 8'($urandom_range(0, 255));
    aux = 1'($urandom_range(0, 1));
    if (r < 35) send_item(MODE_BYTE, 1'b0, b);
    else if (r < 60) send_item(MODE_BYTE, 1'b1, b);
    else if (r < 88) send_item(MODE_CLEAR, aux, b);
    else if (r < 92) send_item(MODE_CENTER, aux, b);
    else send_item(MODE_NONE, aux, b);
  endtask

  // Random traffic: mostly complete packets with random content, sometimes
  // broken up by a stray word between the bytes, plus plain noise words.
  // The sender switches between stretches with and without gaps.
  task automatic send_traffic(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 99) < 3) drift = ~drift;
        for (int k = 0; k < 3; k++) begin
          if (k == 0) send_item(MODE_BYTE, 1'b1, 8'($urandom_range(0, 255)) | SYNC_BIT);
          else send_item(MODE_BYTE, 1'b1, pick_step());
          sent++;
          if (k < 2 && $urandom_range(0, 9) == 0) begin
            send_noise();
            sent++;
          end
        end
      end else begin
        send_noise();
        sent++;
      end
      if (gaps_on && $urandom_range(0, 99) == 0) gaps_on = 1'b0;
      else if (!gaps_on && $urandom_range(0, 99) < 4) gaps_on = 1'b1;
    end
  endtask

  // Watchdog: a run that takes this long has hung somewhere.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d words still expected", CYCLE_LIMIT, pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    mode      <= MODE_BYTE;
    aux_data  <= 1'b0;
    data_byte <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset screen size of 1280 by 720.
    send_item(MODE_BYTE, 1'b0, 8'hFF);    // keyboard byte is ignored
    send_item(MODE_BYTE, 1'b1, 8'hF7);    // no sync bit, dropped
    send_item(MODE_BYTE, 1'b1, 8'h00);    // no sync bit, dropped
    send_item(MODE_BYTE, 1'b1, 8'h0D);    // left and middle pressed
    send_item(MODE_BYTE, 1'b1, 8'h7F);    // largest step right
    send_item(MODE_BYTE, 1'b1, 8'h80);    // largest step down
    send_item(MODE_CLEAR, 1'b0, 8'h00);   // reports the flag set, then clears it
    send_item(MODE_CLEAR, 1'b1, 8'hFF);   // flag already clear
    send_item(MODE_BYTE, 1'b1, 8'hFF);    // sign and overflow bits are ignored
    send_item(MODE_BYTE, 1'b0, 8'h12);    // keyboard byte inside a packet
    send_item(MODE_BYTE, 1'b1, 8'h80);    // largest step left
    send_item(MODE_NONE, 1'b1, 8'hAA);    // unused mode inside a packet
    send_item(MODE_BYTE, 1'b1, 8'h7F);    // largest step up
    send_item(MODE_CENTER, 1'b0, 8'h55);  // recenter
    send_item(MODE_BYTE, 1'b1, 8'h0A);    // right pressed
    send_item(MODE_CENTER, 1'b1, 8'h00);  // recenter leaves the packet phase alone
    send_item(MODE_BYTE, 1'b1, 8'h00);    // no motion
    send_item(MODE_BYTE, 1'b1, 8'h00);
    send_item(MODE_NONE, 1'b0, 8'h00);

    // Smallest screen: every move clamps to the single position.
    set_screen(13'd1, 13'd1);
    send_traffic(150);

    // Largest legal screen. Part way through the receiver holds off for a
    // long time while the sender keeps pushing words with no gaps, so the
    // block fills up and stalls its input. Later the sender pauses until
    // every expected word has come back.
    set_screen(13'd4096, 13'd4096);
    send_traffic(100);
    hold_seq++;
    gaps_on = 1'b0;
    send_traffic(40);
    gaps_on = 1'b1;
    send_traffic(60);
    drain_results();
    send_traffic(100);

    // Zero width acts as one; an oversize height is limited by the
    // coordinate width.
    set_screen(13'd0, 13'd8191);
    send_traffic(200);

    // Random sizes. A smaller screen than before leaves the cursor outside
    // until the next complete packet or recenter pulls it back in.
    repeat (3) begin
      set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      send_traffic(265);
    end

    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
